[hdl/arps_pkg.sv]
// ----------------------------------------------------------------------------
// arps_pkg: shared types and constants of the aging priority scheduler
// Client ring cell layout, priority level mapping, register indexes.
// ----------------------------------------------------------------------------
package arps_pkg;

  localparam int NUM_CLIENTS = 64;
  localparam int CIDX_W      = 6;
  localparam int MIN_PRIO    = -20;
  localparam int MAX_PRIO    = 20;
  localparam int LEVELS      = MAX_PRIO - MIN_PRIO + 1;
  localparam int LVL_W       = 6;
  localparam int TICK_W      = 32;
  localparam int SLICE_W     = 17;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam logic [TICK_W-1:0] LONG_RUN_TICKS = 32'd1000;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_INTERVAL  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLICE_LIMIT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LATENCY_LIMITED = 2'd2;

  typedef struct packed {
    logic signed [5:0]  prio;
    logic [TICK_W-1:0]  stop;
  } cell_t;

  // Priority to level index, clamped to the level table
  function automatic logic [LVL_W-1:0] level_of(logic signed [5:0] p);
    int lv;
    lv = int'(p) - MIN_PRIO;
    if (lv < 0) lv = 0;
    if (lv > LEVELS - 1) lv = LEVELS - 1;
    return LVL_W'(lv);
  endfunction

  // Saturate a raw stop priority to the legal range
  function automatic logic signed [5:0] sat_prio(logic signed [5:0] p);
    logic signed [5:0] r;
    r = p;
    if (int'(p) < MIN_PRIO) r = 6'(MIN_PRIO);
    if (int'(p) > MAX_PRIO) r = 6'(MAX_PRIO);
    return r;
  endfunction

endpackage

[hdl/arps_cell.sv]
// ----------------------------------------------------------------------------
// arps_cell: one client slot of the rotating state ring
// Holds priority and stop tick; loads from its neighbor on shift.
// ----------------------------------------------------------------------------
module arps_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          wr_i,
  input  arps_pkg::cell_t nbr_i,
  input  arps_pkg::cell_t wr_data_i,
  output arps_pkg::cell_t cell_o
);
  import arps_pkg::*;

  cell_t cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (shift_i) begin
      cell_q <= nbr_i;
    end else if (wr_i) begin
      cell_q <= wr_data_i;
    end
  end

  assign cell_o = cell_q;

endmodule

[hdl/arps_ls_ram.sv]
// ----------------------------------------------------------------------------
// arps_ls_ram: last-served client per priority level
// One write and one registered read port; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module arps_ls_ram (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        we_i,
  input  logic [arps_pkg::LVL_W-1:0]  waddr_i,
  input  logic [arps_pkg::CIDX_W-1:0] wdata_i,
  input  logic [arps_pkg::LVL_W-1:0]  raddr_i,
  output logic [arps_pkg::CIDX_W-1:0] rdata_o
);
  import arps_pkg::*;

  logic [CIDX_W-1:0] mem [LEVELS];
  logic [LEVELS-1:0] vld_q;
  logic [CIDX_W-1:0] rdata_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (we_i) vld_q[waddr_i] <= 1'b1;
      rvld_q <= vld_q[raddr_i];
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

[hdl/aging_priority_round_robin_scheduler_top.sv]
// ----------------------------------------------------------------------------
// aging_priority_round_robin_scheduler_top: priority arbiter with aging
// Picks one ready client per schedule beat; records stops; adapts slice.
// ----------------------------------------------------------------------------
// A stop beat returns its result beat in the cycle after it is taken. A
// schedule beat steps through sweep, drain and finish: the 64-slot client ring
// rotates once past the head cell (one client per cycle, aging applied as each
// client passes), the drain state empties the two-stage compare that waits on
// the last-served table read, and the finish state commits the winner and the
// new slice. The input is taken only while the block is idle and its result
// register is free or being emptied. An empty ready mask yields chosen_valid
// low with the slice unchanged. Configuration writes are always taken; write
// them only while idle. No clearing pass is needed after reset.
module aging_priority_round_robin_scheduler_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  // slave stream
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [63:0] ready_mask, [95:64] now, [101:96] client, [107:102] new_priority
  input  logic [111:0] s_axis_tdata_i,
  // [0] op
  input  logic         s_axis_tuser_i,
  // master stream
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [5:0] chosen_client, [22:6] slice_now
  output logic [23:0]  m_axis_tdata_o,
  // [0] chosen_valid
  output logic         m_axis_tuser_o,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [arps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [arps_pkg::CFG_W-1:0]     cfg_data_i
);
  import arps_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DRAIN, ST_FINISH} state_e;

  state_e state_q;

  // configuration registers
  logic [CFG_W-1:0] slice_interval_q, slice_limit_q;
  logic             latency_limited_q;

  // item registers
  logic [NUM_CLIENTS-1:0] mask_q;
  logic [TICK_W-1:0]      now_q;
  logic [CIDX_W-1:0]      cnt_q;

  // scheduler state outside the ring
  logic [SLICE_W-1:0] slice_q;
  logic [CIDX_W:0]    prev_q;        // NUM_CLIENTS marks none
  logic [TICK_W-1:0]  prev_start_q;  // start tick of the previous client

  // compare pipeline
  logic              s1_v_q;
  logic signed [5:0] s1_p_q;
  logic [CIDX_W-1:0] s1_i_q;
  logic [1:0]        seen_q;         // ready clients seen, saturates at two
  logic signed [5:0] best_p_q;
  logic [7:0]        best_r_q;
  logic [CIDX_W-1:0] best_i_q;

  // output register
  logic               out_v_q, out_cv_q;
  logic [CIDX_W-1:0]  out_cl_q;
  logic [SLICE_W-1:0] out_sl_q;

  logic in_acc, out_free;
  assign out_free = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o = 1'b1;

  logic              in_op;
  logic [TICK_W-1:0] in_now;
  logic [CIDX_W-1:0] in_client;
  logic signed [5:0] in_prio;
  assign in_op     = s_axis_tuser_i;
  assign in_now    = s_axis_tdata_i[95:64];
  assign in_client = s_axis_tdata_i[101:96];
  assign in_prio   = s_axis_tdata_i[107:102];

  // ---------------------------------------------------------------- ring
  cell_t ring [NUM_CLIENTS];
  cell_t head_aged, stop_wr;
  logic  shift;
  logic  stop_acc;

  assign shift    = (state_q == ST_SWEEP);
  assign stop_acc = in_acc && in_op;
  assign stop_wr  = '{prio: sat_prio(in_prio), stop: in_now};

  // aging at the head: idle for at least twice the slice, negative priority
  logic [TICK_W-1:0] idle_ticks;
  logic              age;
  assign idle_ticks = now_q - ring[0].stop;
  assign age = mask_q[0] && (ring[0].prio < 0) &&
               (idle_ticks >= {{(TICK_W-SLICE_W-1){1'b0}}, slice_q, 1'b0});
  always_comb begin
    head_aged = ring[0];
    if (age) head_aged.prio = ring[0].prio + 6'sd1;
  end

  for (genvar k = 0; k < NUM_CLIENTS; k++) begin : g_cell
    cell_t nbr;
    if (k == NUM_CLIENTS - 1) begin : g_tail
      assign nbr = head_aged;
    end else begin : g_mid
      assign nbr = ring[k+1];
    end
    arps_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .wr_i     (stop_acc && (in_client == CIDX_W'(k))),
      .nbr_i    (nbr),
      .wr_data_i(stop_wr),
      .cell_o   (ring[k])
    );
  end

  // ---------------------------------------------------- last-served table
  logic [CIDX_W-1:0] ls_rdata;
  logic              ls_we;
  assign ls_we = (state_q == ST_FINISH) && (seen_q != 2'd0);

  arps_ls_ram u_ls (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (ls_we),
    .waddr_i(level_of(best_p_q)),
    .wdata_i(best_i_q),
    .raddr_i(level_of(head_aged.prio)),
    .rdata_o(ls_rdata)
  );

  // round-robin distance, mod 256
  logic [7:0] robin;
  logic       better;
  assign robin  = {2'b00, s1_i_q} - {2'b00, ls_rdata};
  assign better = (seen_q == 2'd0) || (s1_p_q > best_p_q) ||
                  ((s1_p_q == best_p_q) && (robin > best_r_q));

  // ------------------------------------------------------- slice update
  logic [SLICE_W-1:0] slice_d;
  logic [TICK_W-1:0]  run_ticks;
  logic               same;
  assign same      = (prev_q == {1'b0, best_i_q});
  assign run_ticks = now_q - prev_start_q;
  always_comb begin
    slice_d = slice_q;
    if (seen_q == 2'd1 && !latency_limited_q) begin
      // a newly chosen client starts at now, so only a repeat can grow
      if (same && run_ticks > LONG_RUN_TICKS &&
          slice_q < {1'b0, slice_limit_q})
        slice_d = slice_q + {1'b0, slice_interval_q};
    end else begin
      slice_d = {1'b0, slice_interval_q};
    end
  end

  // ----------------------------------------------------------- control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= ST_IDLE;
      slice_interval_q  <= 16'd20;
      slice_limit_q     <= 16'd320;
      latency_limited_q <= 1'b0;
      slice_q           <= 17'd20;
      prev_q            <= (CIDX_W+1)'(NUM_CLIENTS);
      prev_start_q      <= '0;
      s1_v_q            <= 1'b0;
      seen_q            <= '0;
      out_v_q           <= 1'b0;
      cnt_q             <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_SLICE_INTERVAL:  slice_interval_q  <= cfg_data_i;
          REG_SLICE_LIMIT:     slice_limit_q     <= cfg_data_i;
          REG_LATENCY_LIMITED: latency_limited_q <= cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_v_q && m_axis_tready_i) out_v_q <= 1'b0;

      s1_v_q <= (state_q == ST_SWEEP) && mask_q[0];
      if (s1_v_q) begin
        if (better) begin
          best_p_q <= s1_p_q;
          best_r_q <= robin;
          best_i_q <= s1_i_q;
        end
        if (seen_q != 2'd2) seen_q <= seen_q + 2'd1;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_op) begin
              out_v_q  <= 1'b1;
              out_cv_q <= 1'b0;
              out_cl_q <= '0;
              out_sl_q <= slice_q;
            end else begin
              mask_q  <= s_axis_tdata_i[NUM_CLIENTS-1:0];
              now_q   <= in_now;
              cnt_q   <= '0;
              seen_q  <= '0;
              state_q <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          mask_q <= {1'b0, mask_q[NUM_CLIENTS-1:1]};
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CIDX_W'(NUM_CLIENTS - 1)) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          out_v_q <= 1'b1;
          if (seen_q == 2'd0) begin
            out_cv_q <= 1'b0;
            out_cl_q <= '0;
            out_sl_q <= slice_q;
          end else begin
            if (!same) begin
              prev_q       <= {1'b0, best_i_q};
              prev_start_q <= now_q;
            end
            slice_q  <= slice_d;
            out_cv_q <= 1'b1;
            out_cl_q <= best_i_q;
            out_sl_q <= slice_d;
          end
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // stage one payload: the head client after aging
  always_ff @(posedge clk_i) begin
    s1_p_q <= head_aged.prio;
    s1_i_q <= cnt_q;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_cv_q;
  assign m_axis_tdata_o  = {1'b0, out_sl_q, out_cl_q};

`ifndef SYNTHESIS
  a_busy_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready_o)
    else $error("input taken while busy");
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_cv_q) |-> (out_cl_q == '0))
    else $error("invalid result carries a client");
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(state_q == ST_FINISH || (in_acc && in_op)))
    else $error("result beat from nowhere");
  a_sweep_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SWEEP && cnt_q == CIDX_W'(NUM_CLIENTS - 1)) |=>
    (state_q == ST_DRAIN))
    else $error("sweep did not end after the last client");
`endif

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the aging priority round-robin scheduler
// Drives stop and schedule beats, predicts each result beat with a local
// scheduler model or a hand-typed row, and compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import arps_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [111:0] s_axis_tdata_i;
  logic         s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [23:0]  m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  aging_priority_round_robin_scheduler_top dut (.*);

  typedef enum logic {OP_SCHEDULE = 1'b0, OP_STOP = 1'b1} op_e;

  typedef struct {
    op_e               op;
    logic [63:0]       mask;
    logic [31:0]       now;
    logic [5:0]        client;
    logic signed [5:0] prio;
  } sched_req_t;

  typedef struct {
    logic        picked;
    logic [5:0]  client;
    logic [16:0] slice;
  } sched_res_t;

  // directed row: request plus optional hand-typed expectation
  typedef struct {
    sched_req_t req;
    bit         typed;
    sched_res_t res;
  } row_t;

  // predictor state
  logic [15:0]       m_interval, m_limit;
  logic              m_lat_lim;
  logic signed [5:0] m_prio [NUM_CLIENTS];
  logic [31:0]       m_stop [NUM_CLIENTS];
  logic [31:0]       m_start[NUM_CLIENTS];
  logic [7:0]        m_served[LEVELS];
  logic [6:0]        m_prev;
  logic [16:0]       m_slice;

  sched_res_t pending_q[$];
  int         errors;
  bit         calm;        // no idling in the final stretch
  bit         hold_req;    // stimulus asks for one long receiver hold-off
  int         hold_cycles; // remaining hold-off cycles, receiver side
  logic [31:0] tick;

  function automatic int lvl(int p);
    int l;
    l = p - MIN_PRIO;
    if (l < 0) l = 0;
    if (l > LEVELS - 1) l = LEVELS - 1;
    return l;
  endfunction

  function automatic void model_reset();
    m_interval = 16'd20;
    m_limit    = 16'd320;
    m_lat_lim  = 1'b0;
    for (int i = 0; i < NUM_CLIENTS; i++) begin
      m_prio[i] = '0; m_stop[i] = '0; m_start[i] = '0;
    end
    for (int i = 0; i < LEVELS; i++) m_served[i] = '0;
    m_prev  = 7'd64;
    m_slice = 17'd20;
  endfunction

  function automatic sched_res_t schedule_result(sched_req_t r);
    sched_res_t o;
    logic [31:0] idle;
    int best_p, p, cnt, best;
    logic [7:0] robin, best_robin;
    o = '{1'b0, 6'd0, m_slice};
    if (r.op == OP_STOP) begin
      p = int'(r.prio);
      if (p < MIN_PRIO) p = MIN_PRIO;
      if (p > MAX_PRIO) p = MAX_PRIO;
      m_prio[r.client] = 6'(p);
      m_stop[r.client] = r.now;
      return o;
    end
    idle = 32'(2 * m_slice);
    cnt = 0; best = 0; best_p = 0; best_robin = '0;
    for (int i = 0; i < NUM_CLIENTS; i++) begin
      if (!r.mask[i]) continue;
      if (r.now - m_stop[i] >= idle && m_prio[i] < 0) m_prio[i] = m_prio[i] + 6'sd1;
      p = int'(m_prio[i]);
      robin = 8'(i) - m_served[lvl(p)];
      if (cnt == 0 || p > best_p || (p == best_p && robin > best_robin)) begin
        best_p = p; best_robin = robin; best = i;
      end
      cnt++;
    end
    if (cnt == 0) return o;
    m_served[lvl(best_p)] = 8'(best);
    if (m_prev != 7'(best)) begin
      m_start[best] = r.now;
      m_prev = 7'(best);
    end
    if (cnt == 1 && !m_lat_lim) begin
      if (r.now - m_start[best] > 32'd1000 && m_slice < 17'(m_limit))
        m_slice = m_slice + 17'(m_interval);
    end else begin
      m_slice = 17'(m_interval);
    end
    o = '{1'b1, 6'(best), m_slice};
    return o;
  endfunction

  // clock and reset
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // watchdog: cycles without any accepted beat
  int quiet;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      quiet <= 0;
    else if (hold_cycles == 0)
      quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls, long hold-off, and checking
  initial begin
    int gap;
    bit hold_taken;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sched_res_t got, want;
        got = '{m_axis_tuser_o, m_axis_tdata_o[5:0], m_axis_tdata_o[22:6]};
        if (pending_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          want = pending_q.pop_front();
          if (got.picked !== want.picked) begin
            $error("chosen_valid exp %0d got %0d", want.picked, got.picked); errors++;
          end
          if (got.client !== want.client) begin
            $error("chosen_client exp %0d got %0d", want.client, got.client); errors++;
          end
          if (got.slice !== want.slice) begin
            $error("slice_now exp %0d got %0d", want.slice, got.slice); errors++;
          end
        end
      end
      if (hold_req && !hold_taken) begin
        hold_taken  = 1'b1;
        hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_cycles--;
      end else if (!calm && gap == 0 && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 19);
        m_axis_tready_i <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_axis_tready_i <= (gap == 0);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // one input beat, with optional leading idle burst
  task automatic send_beat(sched_req_t r, bit typed, sched_res_t res);
    sched_res_t want;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= r.op;
    s_axis_tdata_i  <= {4'b0, r.prio, r.client, r.now, r.mask};
    do @(posedge clk_i); while (!s_axis_tready_o);
    want = schedule_result(r);
    if (typed) want = res;
    pending_q.push_back(want);
  endtask

  task automatic drain_and_idle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // leaves cfg_valid_i high; the caller drops it after its last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SLICE_INTERVAL:  m_interval = val;
      REG_SLICE_LIMIT:     m_limit    = val;
      REG_LATENCY_LIMITED: m_lat_lim  = val[0];
      default: ;
    endcase
  endtask

  function automatic sched_req_t rand_req(bit heavy);
    sched_req_t r;
    r.op     = op_e'($urandom_range(0, 2) == 0);
    r.client = 6'($urandom);
    r.prio   = 6'($urandom);
    // time moves forward with jumps so aging and long runs both occur
    tick     = tick + ($urandom_range(0, 3) == 0 ? $urandom_range(0, 3000) : $urandom_range(0, 60));
    r.now    = ($urandom_range(0, 40) == 0) ? 32'($urandom) : tick;
    case ($urandom_range(0, 4))
      0: r.mask = 64'd1 << $urandom_range(0, 63);
      1: r.mask = 64'd1 << $urandom_range(0, 3);
      2: r.mask = {$urandom, $urandom};
      3: r.mask = 64'(4'($urandom));
      default: r.mask = heavy ? '1 : 64'($urandom_range(0, 1)) << $urandom_range(0, 63);
    endcase
    return r;
  endfunction

  // stimulus
  initial begin
    row_t rows[$];
    sched_req_t r;
    model_reset();
    calm = 0; hold_req = 1'b0; tick = 32'd5000;
    s_axis_tvalid_i = 1'b0; s_axis_tuser_i = 1'b0; s_axis_tdata_i = '0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // directed table: extremes, saturation, empty mask, ties, aging
    rows.push_back('{'{OP_SCHEDULE, 64'd0, 32'd0, 6'd0, 6'sd0}, 1'b1, '{1'b0, 6'd0, 17'd20}});
    rows.push_back('{'{OP_STOP, 64'd0, 32'hffffffff, 6'd63, 6'sh1f}, 1'b1,
                     '{1'b0, 6'd0, 17'd20}});
    rows.push_back('{'{OP_STOP, '1, 32'd0, 6'd0, 6'sh20}, 1'b1, '{1'b0, 6'd0, 17'd20}});
    rows.push_back('{'{OP_SCHEDULE, 64'd1 << 63, 32'd10, 6'd0, 6'sd0}, 1'b1,
                     '{1'b1, 6'd63, 17'd20}});
    rows.push_back('{'{OP_SCHEDULE, '1, 32'd20, 6'd0, 6'sd0}, 1'b1, '{1'b1, 6'd63, 17'd20}});
    rows.push_back('{'{OP_SCHEDULE, '1, 32'd30, 6'd0, 6'sd0}, 1'b0, '{1'b0, 6'd0, 17'd0}});
    rows.push_back('{'{OP_SCHEDULE, 64'h3, 32'd40, 6'd0, 6'sd0}, 1'b0, '{1'b0, 6'd0, 17'd0}});
    rows.push_back('{'{OP_SCHEDULE, 64'h3, 32'd50, 6'd0, 6'sd0}, 1'b0, '{1'b0, 6'd0, 17'd0}});
    rows.push_back('{'{OP_SCHEDULE, 64'h1, 32'd2000, 6'd0, 6'sd0}, 1'b0,
                     '{1'b0, 6'd0, 17'd0}});
    rows.push_back('{'{OP_SCHEDULE, 64'h1, 32'd4000, 6'd0, 6'sd0}, 1'b0,
                     '{1'b0, 6'd0, 17'd0}});
    rows.push_back('{'{OP_SCHEDULE, 64'h1, 32'd6000, 6'd0, 6'sd0}, 1'b0,
                     '{1'b0, 6'd0, 17'd0}});
    rows.push_back('{'{OP_SCHEDULE, 64'h1, 32'd1, 6'd0, 6'sd0}, 1'b0, '{1'b0, 6'd0, 17'd0}});
    rows.push_back('{'{OP_STOP, 64'd0, 32'd100, 6'd5, 6'sh2a}, 1'b0, '{1'b0, 6'd0, 17'd0}});
    rows.push_back('{'{OP_SCHEDULE, 64'h20, 32'd101, 6'd0, 6'sd0}, 1'b0,
                     '{1'b0, 6'd0, 17'd0}});
    rows.push_back('{'{OP_SCHEDULE, 64'h21, 32'd900, 6'd0, 6'sd0}, 1'b0,
                     '{1'b0, 6'd0, 17'd0}});
    rows.push_back('{'{OP_STOP, 64'd0, 32'd902, 6'd1, 6'sd20}, 1'b0, '{1'b0, 6'd0, 17'd0}});
    rows.push_back('{'{OP_SCHEDULE, 64'h23, 32'd903, 6'd0, 6'sd0}, 1'b0,
                     '{1'b0, 6'd0, 17'd0}});
    rows.push_back('{'{OP_SCHEDULE, 64'hffff_0000_0000_0000, 32'd3, 6'd0, 6'sd0},
                     1'b0, '{1'b0, 6'd0, 17'd0}});
    foreach (rows[i]) send_beat(rows[i].req, rows[i].typed, rows[i].res);

    // random phases over several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_idle();
      case (ph)
        0: begin write_reg(REG_SLICE_INTERVAL, 16'd1); write_reg(REG_SLICE_LIMIT, 16'd65535);
                 write_reg(REG_LATENCY_LIMITED, 16'd0); end
        1: begin write_reg(REG_SLICE_INTERVAL, 16'd65535); write_reg(REG_SLICE_LIMIT, 16'd1); end
        2: begin write_reg(REG_LATENCY_LIMITED, 16'd1); write_reg(REG_SLICE_INTERVAL, 16'd7); end
        3: begin write_reg(REG_LATENCY_LIMITED, 16'd0); write_reg(REG_SLICE_INTERVAL, 16'd300);
                 write_reg(REG_SLICE_LIMIT, 16'd65535); end
        4: begin write_reg(REG_SLICE_INTERVAL, 16'($urandom_range(1, 65535)));
                 write_reg(REG_SLICE_LIMIT, 16'($urandom_range(1, 65535))); end
        default: begin write_reg(REG_SLICE_INTERVAL, 16'd20);
                 write_reg(REG_SLICE_LIMIT, 16'd320); end
      endcase
      cfg_valid_i <= 1'b0;
      if (ph == 5) calm = 1;
      if (ph == 1) hold_req = 1'b1; // receiver stalls long, input backs up
      for (int n = 0; n < 205; n++) begin
        r = rand_req(ph == 3);
        send_beat(r, 1'b0, '{1'b0, 6'd0, 17'd0});
      end
    end

    s_axis_tvalid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[files.f]
hdl/arps_pkg.sv
hdl/arps_cell.sv
hdl/arps_ls_ram.sv
hdl/aging_priority_round_robin_scheduler_top.sv
tb/testbench.sv
